/* design/hkrt_pkg.sv */
// shared constants and types for the hid key report tracker
package hkrt_pkg;

	// default number of key slots in the report
	localparam int KEY_SLOTS_DEFAULT = 10;

	// usage code range of the modifier keys
	localparam logic [7:0] MOD_FIRST = 8'hE0;
	localparam logic [7:0] MOD_LAST  = 8'hE7;

	// usage code that marks an empty slot and is refused as input
	localparam logic [7:0] CODE_NONE = 8'h00;

	// request kinds
	localparam logic REQ_PRESS   = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	// result status codes
	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_BAD_CODE = 1'b1;

	// one key event
	typedef struct packed {
		logic       req_type;
		logic [7:0] key_code;
	} hkrt_item_t;

endpackage

/* design/hkrt_if.sv */
// valid/ready channel interfaces for key events and report results
interface hkrt_req_if ();
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] key_code;

	modport source (output valid, output req_type, output key_code, input ready);
	modport sink (input valid, input req_type, input key_code, output ready);
endinterface

interface hkrt_res_if #(
	parameter int KEY_SLOTS = hkrt_pkg::KEY_SLOTS_DEFAULT
) ();
	logic                      valid;
	logic                      ready;
	logic                      status;
	logic [7:0]                modifier_byte;
	logic [KEY_SLOTS-1:0][7:0] report_key;

	modport source (output valid, output status, output modifier_byte,
		output report_key, input ready);
	modport sink (input valid, input status, input modifier_byte,
		input report_key, output ready);
endinterface

/* design/hid_key_report_tracker_core.sv */
// hid keyboard report tracker: modifier byte and ordered key list per key event
//
//  channel | dir | transfer carries
//  --------+-----+------------------------------------------------------
//  req     | in  | req_type, key_code
//  res     | out | status, modifier_byte, report_key[KEY_SLOTS]
//
// one item per cycle sustained while res.ready stays high; an item taken into the
// input register moves to the result register on the next edge unless the result
// register still holds an untaken result, and its result is offered from there. the
// single slot-compare and shift update lies between the two registers. report state advances
// when an item moves into the result register, so the next item always sees it.
// reset clears the report to empty at once. a stalled result holds the item
// behind it; req.ready drops only when both registers are full and res.ready is low.
module hid_key_report_tracker_core #(
	parameter int KEY_SLOTS = hkrt_pkg::KEY_SLOTS_DEFAULT
) (
	input logic       clk,
	input logic       arst_n,
	hkrt_req_if.sink  req,
	hkrt_res_if.source res
);
	import hkrt_pkg::*;

	logic                      valid_s1;
	hkrt_item_t                item_s1;
	logic                      out_valid_q;
	logic                      advance;
	logic [7:0]                mods_q;
	logic [KEY_SLOTS-1:0][7:0] slots_q;
	logic [7:0]                mods_next;
	logic [KEY_SLOTS-1:0][7:0] slots_next;
	logic                      status_next;
	logic                      status_q;
	logic [7:0]                mod_out_q;
	logic [KEY_SLOTS-1:0][7:0] keys_out_q;
	logic                      compact_ok;

	// handshake control
	assign advance   = valid_s1 && (!out_valid_q || res.ready);
	assign req.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.req_type <= req.req_type;
			item_s1.key_code <= req.key_code;
		end
	end

	// event update
	hkrt_slot_update #(
		.KEY_SLOTS(KEY_SLOTS)
	) u_update (
		.item      (item_s1),
		.mods      (mods_q),
		.slots     (slots_q),
		.mods_next (mods_next),
		.slots_next(slots_next),
		.status    (status_next)
	);

	// report state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mods_q      <= '0;
			slots_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				mods_q  <= mods_next;
				slots_q <= slots_next;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance) begin
			status_q   <= status_next;
			mod_out_q  <= mods_next;
			keys_out_q <= slots_next;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.status        = status_q;
	assign res.modifier_byte = mod_out_q;
	assign res.report_key    = keys_out_q;

	// no empty slot below an occupied one
	always_comb begin
		compact_ok = 1'b1;
		for (int i = 1; i < KEY_SLOTS; i++) begin
			if (slots_q[i-1] == CODE_NONE && slots_q[i] != CODE_NONE) begin
				compact_ok = 1'b0;
			end
		end
	end

	// checks
	a_compact: assert property (@(posedge clk) disable iff (!arst_n) compact_ok)
		else $error("key list lost compactness");

	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(slots_q) && $stable(mods_q))
		else $error("report state moved without an item advancing");

	a_result_matches: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res.valid && res.report_key == slots_q && res.modifier_byte == mods_q)
		else $error("result does not match report state");

	a_bad_code: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.key_code == CODE_NONE |=>
		$stable(slots_q) && $stable(mods_q) && res.status == STATUS_BAD_CODE)
		else $error("invalid code changed state or status");

endmodule

/* design/hkrt_slot_update.sv */
// next report state for one key event: modifier bits and compact key list
module hkrt_slot_update #(
	parameter int KEY_SLOTS = hkrt_pkg::KEY_SLOTS_DEFAULT
) (
	input  hkrt_pkg::hkrt_item_t       item,
	input  logic [7:0]                 mods,
	input  logic [KEY_SLOTS-1:0][7:0]  slots,
	output logic [7:0]                 mods_next,
	output logic [KEY_SLOTS-1:0][7:0]  slots_next,
	output logic                       status
);
	import hkrt_pkg::*;

	logic [KEY_SLOTS-1:0]      match;
	logic [KEY_SLOTS-1:0]      occ;
	logic [KEY_SLOTS-1:0]      first_empty;
	logic [KEY_SLOTS-1:0]      at_or_after;
	logic [KEY_SLOTS-1:0][7:0] shift_dn;
	logic                      held;
	logic                      full;
	logic                      is_mod;
	logic [7:0]                mod_bit;

	// per-slot compare against the code and occupancy
	always_comb begin
		for (int i = 0; i < KEY_SLOTS; i++) begin
			match[i] = (slots[i] == item.key_code);
			occ[i]   = (slots[i] != CODE_NONE);
		end
	end

	// list is compact, so the first empty slot sits just above the occupied run
	assign first_empty = ~occ & ((occ << 1) | KEY_SLOTS'(1));
	// slots at or above the one-hot hit; all zero when nothing matched
	assign at_or_after = ~(match - KEY_SLOTS'(1));
	assign shift_dn    = slots >> 8;
	assign held        = |match;
	assign full        = occ[KEY_SLOTS-1];
	assign is_mod      = item.key_code inside {[MOD_FIRST:MOD_LAST]};
	assign mod_bit     = 8'(1) << item.key_code[2:0];

	// apply the event
	always_comb begin
		mods_next  = mods;
		slots_next = slots;
		status     = STATUS_OK;
		if (item.key_code == CODE_NONE) begin
			status = STATUS_BAD_CODE;
		end else if (is_mod) begin
			if (item.req_type == REQ_RELEASE) begin
				mods_next = mods & ~mod_bit;
			end else begin
				mods_next = mods | mod_bit;
			end
		end else if (item.req_type == REQ_RELEASE) begin
			// drop the hit and pull the rest down one slot
			for (int i = 0; i < KEY_SLOTS; i++) begin
				if (at_or_after[i]) begin
					slots_next[i] = shift_dn[i];
				end
			end
		end else if (!held) begin
			if (full) begin
				// evict the oldest key and append at the end
				slots_next                = shift_dn;
				slots_next[KEY_SLOTS-1] = item.key_code;
			end else begin
				for (int i = 0; i < KEY_SLOTS; i++) begin
					if (first_empty[i]) begin
						slots_next[i] = item.key_code;
					end
				end
			end
		end
	end

endmodule

/* test/tb_hid_key_report_tracker_core.sv */
// self-checking testbench for the hid key report tracker: random key events against a report predictor
module tb_hid_key_report_tracker_core;
	timeunit 1ns;
	timeprecision 1ps;

	import hkrt_pkg::*;

	localparam int KEY_SLOTS = KEY_SLOTS_DEFAULT;
	localparam int RANDOM_EVENTS = 2000;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 10;

	// full report as seen after one key event
	typedef struct packed {
		logic                      status;
		logic [7:0]                modifier_byte;
		logic [KEY_SLOTS-1:0][7:0] report_key;
	} key_report_t;

	logic clk;
	logic arst_n;

	hkrt_req_if req_ch ();
	hkrt_res_if #(.KEY_SLOTS(KEY_SLOTS)) res_ch ();

	hid_key_report_tracker_core #(
		.KEY_SLOTS(KEY_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.res(res_ch)
	);

	// predicted report state
	logic [7:0]                held_mods;
	logic [KEY_SLOTS-1:0][7:0] held_keys;

	hkrt_item_t  pending_events[$];
	key_report_t expected_reports[$];

	int total_events;
	int events_sent;
	int reports_checked;
	int errors;
	int cycles;
	int presses_seen;
	int releases_seen;
	int bad_codes_seen;
	int modifier_events;
	int evictions;

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// apply one key event to the predicted state and return the report after it
	function automatic key_report_t advance_report(input hkrt_item_t ev);
		key_report_t r;
		int pos;
		int i;
		r.status = STATUS_OK;
		pos = -1;
		if (ev.key_code == CODE_NONE) begin
			r.status = STATUS_BAD_CODE;
			bad_codes_seen++;
		end else if (ev.key_code >= MOD_FIRST && ev.key_code <= MOD_LAST) begin
			modifier_events++;
			held_mods[ev.key_code[2:0]] = (ev.req_type == REQ_PRESS);
		end else begin
			for (i = 0; i < KEY_SLOTS; i++) begin
				if (pos < 0 && held_keys[i] == ev.key_code)
					pos = i;
			end
			if (ev.req_type == REQ_RELEASE) begin
				releases_seen++;
				// remove the key and close the gap
				if (pos >= 0) begin
					for (i = pos; i < KEY_SLOTS - 1; i++)
						held_keys[i] = held_keys[i + 1];
					held_keys[KEY_SLOTS - 1] = CODE_NONE;
				end
			end else begin
				presses_seen++;
				if (pos < 0) begin
					if (held_keys[KEY_SLOTS - 1] != CODE_NONE) begin
						// full list: drop the oldest, append at the end
						for (i = 0; i < KEY_SLOTS - 1; i++)
							held_keys[i] = held_keys[i + 1];
						held_keys[KEY_SLOTS - 1] = ev.key_code;
						evictions++;
					end else begin
						pos = -1;
						for (i = 0; i < KEY_SLOTS; i++) begin
							if (pos < 0 && held_keys[i] == CODE_NONE)
								pos = i;
						end
						held_keys[pos] = ev.key_code;
					end
				end
			end
		end
		r.modifier_byte = held_mods;
		r.report_key = held_keys;
		return r;
	endfunction

	task automatic queue_event(input logic kind, input logic [7:0] code);
		hkrt_item_t ev;
		ev.req_type = kind;
		ev.key_code = code;
		pending_events.push_back(ev);
	endtask

	// driver: bursts of key events with random gaps
	always @(posedge clk or negedge arst_n) begin : drive_events
		hkrt_item_t ev;
		hkrt_item_t sent;
		int burst_left;
		int gap_left;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.req_type <= REQ_PRESS;
			req_ch.key_code <= CODE_NONE;
			burst_left = 0;
			gap_left = 0;
		end else begin
			// predict on the transfer just made
			if (req_ch.valid && req_ch.ready) begin
				sent.req_type = req_ch.req_type;
				sent.key_code = req_ch.key_code;
				expected_reports.push_back(advance_report(sent));
				events_sent++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (gap_left > 0 || pending_events.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					req_ch.valid <= 1'b0;
				end else begin
					ev = pending_events.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.req_type <= ev.req_type;
					req_ch.key_code <= ev.key_code;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 32);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left--;
					end
				end
			end
		end
	end

	// monitor: stalls on its own pattern and checks each report transfer
	always @(posedge clk or negedge arst_n) begin : check_reports
		key_report_t want;
		logic [15:0] stall_pat;
		int pat_pos;
		int pat_age;
		int i;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			stall_pat = 16'hFFFF;
			pat_pos = 0;
			pat_age = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_reports.size() == 0) begin
					$display("%0t: unexpected report status=%0b mods=%h keys=%h", $time,
						res_ch.status, res_ch.modifier_byte, res_ch.report_key);
					errors++;
				end else begin
					want = expected_reports.pop_front();
					reports_checked++;
					if (res_ch.status !== want.status) begin
						$display("%0t: status expected %0b actual %0b", $time,
							want.status, res_ch.status);
						errors++;
					end
					if (res_ch.modifier_byte !== want.modifier_byte) begin
						$display("%0t: modifier_byte expected %h actual %h", $time,
							want.modifier_byte, res_ch.modifier_byte);
						errors++;
					end
					for (i = 0; i < KEY_SLOTS; i++) begin
						if (res_ch.report_key[i] !== want.report_key[i]) begin
							$display("%0t: report_key_%0d expected %h actual %h", $time, i,
								want.report_key[i], res_ch.report_key[i]);
							errors++;
						end
					end
				end
			end
			// pick a new stall pattern now and then
			pat_age++;
			if (pat_age >= 64) begin
				pat_age = 0;
				case ($urandom_range(0, 2))
					0: stall_pat = 16'hFFFF;
					1: stall_pat = 16'($urandom());
					default: stall_pat = 16'($urandom() & $urandom()) | 16'h0001;
				endcase
			end
			res_ch.ready <= stall_pat[pat_pos];
			pat_pos = (pat_pos + 1) % 16;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: run limit reached, %0d reports outstanding", $time,
				expected_reports.size());
			$display("** hid_key_report_tracker_core: FAILED **");
			$finish;
		end
	end

	// stimulus and end of run
	initial begin : stimulus
		int seg_len;
		int pool_lo;
		int pool_sz;
		int press_pct;
		int sel;
		int n;
		logic kind;
		logic [7:0] code;

		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_PRESS;
		req_ch.key_code = CODE_NONE;
		res_ch.ready = 1'b0;
		held_mods = '0;
		held_keys = '0;
		errors = 0;
		cycles = 0;
		events_sent = 0;
		reports_checked = 0;
		presses_seen = 0;
		releases_seen = 0;
		bad_codes_seen = 0;
		modifier_events = 0;
		evictions = 0;

		// directed: bad code, modifier edges, overflow, compaction
		queue_event(REQ_PRESS, CODE_NONE);
		queue_event(REQ_RELEASE, CODE_NONE);
		queue_event(REQ_PRESS, MOD_FIRST);
		queue_event(REQ_PRESS, MOD_LAST);
		queue_event(REQ_PRESS, MOD_FIRST);
		queue_event(REQ_RELEASE, 8'hE3);
		queue_event(REQ_RELEASE, MOD_LAST);
		queue_event(REQ_PRESS, 8'hFF);
		queue_event(REQ_PRESS, 8'hDF);
		queue_event(REQ_PRESS, 8'hE8);
		for (int k = 1; k <= 8; k++)
			queue_event(REQ_PRESS, k[7:0]);
		queue_event(REQ_PRESS, 8'h04);
		queue_event(REQ_RELEASE, 8'h05);
		queue_event(REQ_RELEASE, 8'h7F);
		queue_event(REQ_PRESS, CODE_NONE);
		queue_event(REQ_RELEASE, 8'hDF);
		queue_event(REQ_RELEASE, 8'h08);
		queue_event(REQ_RELEASE, MOD_FIRST);

		// random: segments over a small pool of codes so the list fills and drains
		n = 0;
		while (n < RANDOM_EVENTS) begin
			seg_len = $urandom_range(50, 250);
			pool_lo = $urandom_range(1, 200);
			pool_sz = $urandom_range(2, 24);
			press_pct = $urandom_range(35, 70);
			for (int k = 0; k < seg_len && n < RANDOM_EVENTS; k++) begin
				sel = $urandom_range(0, 99);
				if (sel < 4)
					code = CODE_NONE;
				else if (sel < 14)
					code = MOD_FIRST + 8'($urandom_range(0, 7));
				else if (sel < 24)
					code = 8'($urandom_range(0, 255));
				else
					code = 8'(pool_lo + $urandom_range(0, pool_sz - 1));
				kind = ($urandom_range(0, 99) < press_pct) ? REQ_PRESS : REQ_RELEASE;
				queue_event(kind, code);
				n++;
			end
		end
		total_events = pending_events.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// wait for every event to go in and every report to come back
		while (events_sent < total_events)
			@(posedge clk);
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("checked %0d reports: %0d presses, %0d releases, %0d modifier events,",
			reports_checked, presses_seen, releases_seen, modifier_events);
		$display("%0d bad codes, %0d oldest-key drops from a full list, %0d errors",
			bad_codes_seen, evictions, errors);
		if (errors == 0)
			$display("** hid_key_report_tracker_core: PASSED **");
		else
			$display("** hid_key_report_tracker_core: FAILED **");
		$finish;
	end

endmodule
